/* hdl/pwwl_pkg.sv */
// pwwl_pkg: shared types and constants of the pulse wave window level block
// no dependencies; imported by every module of the block

package pwwl_pkg;

	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned LEVEL_W     = 8;
	// scale of 15 doubled for the half-up rounding of the level
	localparam int unsigned LEVEL_MULT  = 30;
	localparam int unsigned MULT_W      = 5;
	localparam int unsigned LEVEL_MAX   = 255;
	localparam logic [15:0] SAMPLE_MAX  = 16'hFFFF;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV1,
		ST_DIV2,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
	} scan_res_t;

endpackage

/* hdl/pwwl_win.sv */
// pwwl_win: circular sample window memory with a min/max scan sequencer
// depends on pwwl_pkg

module pwwl_win #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7,
	parameter int unsigned FW    = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [pwwl_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                       scan_start,
	input  logic [FW-1:0]              fill,
	output pwwl_pkg::scan_res_t        scan_res
);
	import pwwl_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic [FW-1:0]       idx_q;
	logic                scanning_q;
	logic                rd_pend_s1;
	logic                done_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic                issue;
	logic                finish;

	// writes only happen while no scan runs, so reads never meet a write in flight
	assign issue  = scanning_q && (idx_q < fill);
	assign finish = scanning_q && !issue && !rd_pend_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
			done_q     <= 1'b0;
			idx_q      <= '0;
		end else begin
			done_q     <= finish;
			rd_pend_s1 <= issue;
			if (scan_start) begin
				scanning_q <= 1'b1;
				idx_q      <= '0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + FW'(1);
				end
				if (finish) begin
					scanning_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			lo_q <= SAMPLE_MAX;
			hi_q <= '0;
		end else if (rd_pend_s1) begin
			if (rd_data_s1 < lo_q) begin
				lo_q <= rd_data_s1;
			end
			if (rd_data_s1 > hi_q) begin
				hi_q <= rd_data_s1;
			end
		end
	end

	assign scan_res.done = done_q;
	assign scan_res.lo   = lo_q;
	assign scan_res.hi   = hi_q;

endmodule

/* hdl/pwwl_div.sv */
// pwwl_div: restoring divider, one quotient bit per cycle, shared by both divisions
// depends on pwwl_pkg

module pwwl_div #(
	parameter int unsigned DVD_W = 27,
	parameter int unsigned DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	import pwwl_pkg::*;

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] step_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = !diff[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - CNT_W'(1);
				if (step_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in from the right as the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* hdl/pulse_wave_window_level_core.sv */
// pulse_wave_window_level_core: top level of the pulse wave window level block
// depends on pwwl_pkg, pwwl_win and pwwl_div
//
// usage:
//   input channel  in_valid/in_ready carries op, sample and last. op clear empties
//   the window and restarts the batch; op sample writes the sample into the window
//   and adds it to the batch. a sample with last set, or one that fills a batch of
//   MAX_BATCH, ends the batch and yields one item on the output channel.
//   output channel out_valid/out_ready carries level, saturated and flat_window.
//   a clear or a sample that does not end a batch leaves in_ready high for the next item.
//   a batch-ending sample holds in_ready low while the window scan reads one memory
//   entry a cycle over the fill count, then while the serial divider runs once by
//   the batch count and once by the window range, one quotient bit per cycle each
//   (SW+5 = 27 bits at MAX_BATCH = 64); a flat window skips the divider.
//   the output register lets the next item in while a result waits; if the
//   receiver still stalls when the following result is ready, the block holds it
//   and keeps in_ready low until the output register frees.
//   reset empties the window by clearing the fill count; no memory sweep is needed.

module pulse_wave_window_level_core #(
	parameter int unsigned WINDOW_DEPTH = 128,
	parameter int unsigned MAX_BATCH    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [pwwl_pkg::SAMPLE_W-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pwwl_pkg::LEVEL_W-1:0]  level,
	output logic                          saturated,
	output logic                          flat_window
);
	import pwwl_pkg::*;

	localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned CW = $clog2(MAX_BATCH + 1);
	localparam int unsigned SW = SAMPLE_W + $clog2(MAX_BATCH);
	localparam int unsigned DW = SW + MULT_W;

	state_t              state_q, state_d;
	logic                in_acc;
	logic                is_sample;
	logic                batch_end;
	logic [AW-1:0]       wp_q;
	logic [FW-1:0]       fill_q;
	logic [SW-1:0]       sum_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_new;
	logic                scan_go_q;
	scan_res_t           scan_res;
	logic [SAMPLE_W-1:0] range_q;
	logic                div_start;
	logic [DW-1:0]       div_dvd;
	logic [SAMPLE_W-1:0] div_dvs;
	logic                div_done;
	logic [DW-1:0]       div_quo;
	logic [DW-1:0]       lvl_full;
	logic                flat;
	logic                out_free;
	logic [LEVEL_W-1:0]  res_level_q;
	logic                res_sat_q;
	logic                res_flat_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                saturated_q;
	logic                flat_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign is_sample = in_acc && (op == OP_SAMPLE);
	assign cnt_new   = cnt_q + CW'(1);
	assign batch_end = last || (cnt_new == CW'(MAX_BATCH));
	assign flat      = (scan_res.hi <= scan_res.lo);
	assign out_free  = !out_valid_q || out_ready;
	// halve rounding half up
	assign lvl_full  = (div_quo >> 1) + DW'(div_quo[0]);

	pwwl_win #(
		.DEPTH (WINDOW_DEPTH),
		.AW    (AW),
		.FW    (FW)
	) u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (is_sample),
		.wr_addr    (wp_q),
		.wr_data    (sample),
		.scan_start (scan_go_q),
		.fill       (fill_q),
		.scan_res   (scan_res)
	);

	pwwl_div #(
		.DVD_W (DW),
		.DVS_W (SAMPLE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = DW'(sum_q) * DW'(LEVEL_MULT);
		div_dvs   = SAMPLE_W'(cnt_q);
		unique case (state_q)
			ST_IDLE: begin
				if (is_sample && batch_end) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_res.done) begin
					if (flat) begin
						state_d = ST_EMIT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV1;
					end
				end
			end
			ST_DIV1: begin
				div_dvd = div_quo;
				div_dvs = range_q;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV2;
				end
			end
			ST_DIV2: begin
				div_dvd = div_quo;
				div_dvs = range_q;
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// window position, fill count, batch accumulators and scan start strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			scan_go_q <= 1'b0;
		end else begin
			scan_go_q <= is_sample && batch_end;
			if (in_acc && (op == OP_CLEAR)) begin
				wp_q   <= '0;
				fill_q <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
			end else if (is_sample) begin
				wp_q  <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
				sum_q <= sum_q + SW'(sample);
				cnt_q <= cnt_new;
				if (fill_q != FW'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + FW'(1);
				end
			end else if ((state_q == ST_SCAN) && scan_res.done) begin
				// batch is loaded into the divider here, or dropped for a flat window
				sum_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && scan_res.done) begin
			range_q     <= scan_res.hi - scan_res.lo;
			res_level_q <= '0;
			res_sat_q   <= 1'b0;
			res_flat_q  <= flat;
		end else if ((state_q == ST_DIV2) && div_done) begin
			if (lvl_full > DW'(LEVEL_MAX)) begin
				res_level_q <= LEVEL_W'(LEVEL_MAX);
				res_sat_q   <= 1'b1;
			end else begin
				res_level_q <= lvl_full[LEVEL_W-1:0];
				res_sat_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			level_q     <= res_level_q;
			saturated_q <= res_sat_q;
			flat_q      <= res_flat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign level       = level_q;
	assign saturated   = saturated_q;
	assign flat_window = flat_q;

endmodule

/* hdl/pwwl_checker.sv */
// pwwl_checker: port-level assertions for the pulse wave window level block
// depends on pwwl_pkg; bound to pulse_wave_window_level_core below

module pwwl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         op,
	input logic                         last,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pwwl_pkg::LEVEL_W-1:0] level,
	input logic                         saturated,
	input logic                         flat_window
);
	import pwwl_pkg::*;

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(saturated)
			&& $stable(flat_window))
		else $error("result changed while stalled");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_window |-> (level == '0) && !saturated)
		else $error("flat window result not zero");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (level == LEVEL_W'(LEVEL_MAX)) && !flat_window)
		else $error("saturated result not at maximum");

	// a sample with last set starts the scan and blocks the input
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_SAMPLE) && last |=> !in_ready)
		else $error("input taken during batch evaluation");

endmodule

bind pulse_wave_window_level_core pwwl_checker u_pwwl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.op          (op),
	.last        (last),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.level       (level),
	.saturated   (saturated),
	.flat_window (flat_window)
);
